/* design/indexed_ordered_list_defines.svh */
// assertion macros for the indexed ordered list checker
// no dependencies; expects aclk and aresetn in the scope of each use
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IOL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("indexed_ordered_list: check failed");

// next-cycle implication, disabled during reset
`define IOL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed_ordered_list: check failed");

`endif

/* design/iol_pkg.sv */
// shared constants, codes and structs for the indexed ordered list
// no dependencies; used by iol_cell, iol_ctrl and the top level
package iol_pkg;

    // list depth and derived widths
    localparam int MAX_ENTRIES = 64;
    localparam int POS_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = 7;
    localparam int WIDE_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // word field widths
    localparam int MODE_W   = 4;
    localparam int SUIT_W   = 2;
    localparam int RANK_W   = 4;
    localparam int CARD_W   = SUIT_W + RANK_W;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_INS_INDEX = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_REPLACE   = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_READ      = MODE_W'(4);
    localparam logic [MODE_W-1:0] MODE_SEARCH    = MODE_W'(5);
    localparam logic [MODE_W-1:0] MODE_RM_MATCH  = MODE_W'(6);
    localparam logic [MODE_W-1:0] MODE_RM_FRONT  = MODE_W'(7);
    localparam logic [MODE_W-1:0] MODE_RM_BACK   = MODE_W'(8);
    localparam logic [MODE_W-1:0] MODE_RM_INDEX  = MODE_W'(9);
    localparam logic [MODE_W-1:0] MODE_CLEAR     = MODE_W'(10);

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
    localparam logic [STAT_W-1:0] STAT_RANGE = STAT_W'(1);
    localparam logic [STAT_W-1:0] STAT_EMPTY = STAT_W'(2);
    localparam logic [STAT_W-1:0] STAT_FULL  = STAT_W'(3);

    // action broadcast to every cell
    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_INSERT,
        ACT_REPLACE,
        ACT_READ,
        ACT_SEARCH,
        ACT_RMMATCH,
        ACT_REMOVE
    } act_t;

    typedef struct packed {
        act_t              act;
        logic [CARD_W-1:0] card;
        logic [WIDE_W-1:0] pos;
        logic [WIDE_W-1:0] cnt;
    } op_t;

    // token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic              active;
        logic [POS_W-1:0]  idx;
        logic              hit;
        logic [CARD_W-1:0] carry;
        logic [CARD_W-1:0] got;
    } tok_t;

endpackage

/* design/iol_cell.sv */
// one list cell: holds one card and acts when the sweep token passes
// depends on iol_pkg
module iol_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  iol_pkg::op_t               op,
    input  iol_pkg::tok_t              tok_in,
    input  logic [iol_pkg::CARD_W-1:0] right_card,
    output logic [iol_pkg::CARD_W-1:0] card,
    output iol_pkg::tok_t              tok_out
);

    logic [iol_pkg::CARD_W-1:0] card_reg, card_next;
    iol_pkg::tok_t              tok_reg, tok_next;
    logic [iol_pkg::WIDE_W-1:0] my_pos;
    logic                       at_pos, past_pos, in_list, match;

    // position compares and card match
    always_comb begin
        my_pos   = iol_pkg::WIDE_W'(tok_in.idx);
        at_pos   = (my_pos == op.pos);
        past_pos = (my_pos > op.pos);
        in_list  = (my_pos < op.cnt);
        match    = (card_reg == op.card);
    end

    // cell action while the token is here
    always_comb begin
        card_next    = card_reg;
        tok_next     = tok_in;
        tok_next.idx = tok_in.idx + iol_pkg::POS_W'(1);
        if (tok_in.active) begin
            case (op.act)
                iol_pkg::ACT_INSERT: begin
                    if (at_pos) begin
                        card_next      = op.card;
                        tok_next.carry = card_reg;
                    end else if (past_pos && (my_pos <= op.cnt)) begin
                        card_next      = tok_in.carry;
                        tok_next.carry = card_reg;
                    end
                end
                iol_pkg::ACT_REPLACE: begin
                    if (at_pos) card_next = op.card;
                end
                iol_pkg::ACT_READ: begin
                    if (at_pos) tok_next.got = card_reg;
                end
                iol_pkg::ACT_SEARCH: begin
                    if (in_list && match) tok_next.hit = 1'b1;
                end
                iol_pkg::ACT_RMMATCH: begin
                    if (in_list) begin
                        if (!tok_in.hit && match) begin
                            tok_next.hit = 1'b1;
                            tok_next.got = card_reg;
                        end
                        // close the gap behind the first match
                        if (tok_in.hit || match) card_next = right_card;
                    end
                end
                iol_pkg::ACT_REMOVE: begin
                    if (at_pos) tok_next.got = card_reg;
                    if ((at_pos || past_pos) && in_list) card_next = right_card;
                end
                default: ;
            endcase
        end
    end

    // card storage, no reset
    always_ff @(posedge aclk) begin
        card_reg <= card_next;
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign card    = card_reg;
    assign tok_out = tok_reg;

endmodule

/* design/iol_ctrl.sv */
// control: decodes a word, launches the sweep token, builds the result word
// depends on iol_pkg
module iol_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [iol_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [iol_pkg::M_DATA_W-1:0] m_tdata,
    output iol_pkg::op_t                 op,
    output iol_pkg::tok_t                launch,
    input  iol_pkg::tok_t                ret
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    iol_pkg::op_t                 op_reg, op_next, dec_op;
    iol_pkg::tok_t                launch_reg, launch_next;
    logic [iol_pkg::STAT_W-1:0]   status_reg, status_next, dec_status;
    logic [iol_pkg::WIDE_W-1:0]   cnt_after_reg, cnt_after_next, dec_cnt;
    logic [iol_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         found_reg, found_next;
    logic [iol_pkg::CARD_W-1:0]   got_reg, got_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [iol_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [iol_pkg::MODE_W-1:0]   in_mode;
    logic [iol_pkg::CARD_W-1:0]   in_card;
    logic [iol_pkg::WIDE_W-1:0]   in_idx, cur_cnt, max_cnt, ins_pos;
    logic                         accept, out_free, ret_hit;

    // input word fields
    assign in_mode = s_tdata[3:0];
    assign in_card = {s_tdata[5:4], s_tdata[9:6]};
    assign in_idx  = iol_pkg::WIDE_W'(s_tdata[16:10]);
    assign cur_cnt = iol_pkg::WIDE_W'(count_reg);
    assign max_cnt = iol_pkg::WIDE_W'(iol_pkg::MAX_ENTRIES);

    // decode: checks against the count and picks the cell action
    always_comb begin
        dec_op.act  = iol_pkg::ACT_NOP;
        dec_op.card = in_card;
        dec_op.pos  = '0;
        dec_op.cnt  = cur_cnt;
        dec_status  = iol_pkg::STAT_OK;
        dec_cnt     = cur_cnt;
        if (in_mode == iol_pkg::MODE_INS_FRONT) begin
            ins_pos = '0;
        end else if (in_mode == iol_pkg::MODE_INS_BACK) begin
            ins_pos = cur_cnt;
        end else begin
            ins_pos = in_idx;
        end
        case (in_mode)
            iol_pkg::MODE_INS_FRONT, iol_pkg::MODE_INS_BACK, iol_pkg::MODE_INS_INDEX: begin
                if (cur_cnt >= max_cnt) begin
                    dec_status = iol_pkg::STAT_FULL;
                end else if (ins_pos > cur_cnt) begin
                    dec_status = iol_pkg::STAT_RANGE;
                end else begin
                    dec_op.act = iol_pkg::ACT_INSERT;
                    dec_op.pos = ins_pos;
                    dec_cnt    = cur_cnt + iol_pkg::WIDE_W'(1);
                end
            end
            iol_pkg::MODE_REPLACE, iol_pkg::MODE_READ, iol_pkg::MODE_RM_INDEX: begin
                if (cur_cnt == '0) begin
                    dec_status = iol_pkg::STAT_EMPTY;
                end else if (in_idx >= cur_cnt) begin
                    dec_status = iol_pkg::STAT_RANGE;
                end else begin
                    dec_op.pos = in_idx;
                    if (in_mode == iol_pkg::MODE_REPLACE) begin
                        dec_op.act = iol_pkg::ACT_REPLACE;
                    end else if (in_mode == iol_pkg::MODE_READ) begin
                        dec_op.act = iol_pkg::ACT_READ;
                    end else begin
                        dec_op.act = iol_pkg::ACT_REMOVE;
                        dec_cnt    = cur_cnt - iol_pkg::WIDE_W'(1);
                    end
                end
            end
            iol_pkg::MODE_SEARCH, iol_pkg::MODE_RM_MATCH: begin
                if (cur_cnt == '0) begin
                    dec_status = iol_pkg::STAT_EMPTY;
                end else if (in_mode == iol_pkg::MODE_SEARCH) begin
                    dec_op.act = iol_pkg::ACT_SEARCH;
                end else begin
                    dec_op.act = iol_pkg::ACT_RMMATCH;
                end
            end
            iol_pkg::MODE_RM_FRONT, iol_pkg::MODE_RM_BACK: begin
                if (cur_cnt == '0) begin
                    dec_status = iol_pkg::STAT_EMPTY;
                end else begin
                    dec_op.act = iol_pkg::ACT_REMOVE;
                    dec_op.pos = (in_mode == iol_pkg::MODE_RM_FRONT) ? '0
                                                                     : cur_cnt - iol_pkg::WIDE_W'(1);
                    dec_cnt    = cur_cnt - iol_pkg::WIDE_W'(1);
                end
            end
            iol_pkg::MODE_CLEAR: begin
                dec_cnt = '0;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ret_hit  = ret.hit && ((op_reg.act == iol_pkg::ACT_SEARCH) ||
                                  (op_reg.act == iol_pkg::ACT_RMMATCH));

    // sequencer
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        launch_next    = launch_reg;
        status_next    = status_reg;
        cnt_after_next = cnt_after_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        got_next       = got_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        launch_next.active = 1'b0;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next            = dec_op;
                    status_next        = dec_status;
                    cnt_after_next     = dec_cnt;
                    launch_next.active = 1'b1;
                    launch_next.idx    = '0;
                    launch_next.hit    = 1'b0;
                    launch_next.carry  = '0;
                    launch_next.got    = '0;
                    state_next         = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // token back from the last cell
                if (ret.active) begin
                    found_next = ret_hit;
                    got_next   = ret.got;
                    if (ret_hit && (op_reg.act == iol_pkg::ACT_RMMATCH)) begin
                        cnt_after_next = cnt_after_reg - iol_pkg::WIDE_W'(1);
                    end
                    count_next = (ret_hit && (op_reg.act == iol_pkg::ACT_RMMATCH))
                               ? iol_pkg::CNT_W'(cnt_after_reg - iol_pkg::WIDE_W'(1))
                               : iol_pkg::CNT_W'(cnt_after_reg);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cnt_after_reg[iol_pkg::IDX_W-1:0], status_reg,
                                     found_reg, got_reg[3:0], got_reg[5:4]};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            launch_reg.active <= 1'b0;
            count_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        cnt_after_reg <= cnt_after_next;
        found_reg     <= found_next;
        got_reg       <= got_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign op       = op_reg;
    assign launch   = launch_reg;

endmodule

/* design/indexed_ordered_list.sv */
// top level of the indexed ordered list: control plus a row of cells
// depends on iol_pkg, iol_cell and iol_ctrl
//
//   channel  dir  ports                        word
//   s_       in   s_tvalid s_tready s_tdata    one list operation
//   m_       out  m_tvalid m_tready m_tdata    one result per operation
//
// a word is accepted only in idle, after the previous one has swept the row and
// its result word is built; the token walks the cell row one cell per cycle
// a new word is taken while the previous result still waits on m_
// reset (aresetn low, synchronous) empties the list; card storage is not cleared
// a stall on m_ holds the finished result; the next word still sweeps, then its
// result waits in control with s_tready low until m_ frees up
module indexed_ordered_list (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [3:0] mode, [5:4] suit, [9:6] rank, [16:10] index, [23:17] zero
    input  logic [iol_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] out_suit, [5:2] out_rank, [6] found, [8:7] status, [15:9] entry_count
    output logic [iol_pkg::M_DATA_W-1:0] m_tdata
);

    iol_pkg::op_t               op;
    iol_pkg::tok_t              tok   [iol_pkg::MAX_ENTRIES+1];
    logic [iol_pkg::CARD_W-1:0] cards [iol_pkg::MAX_ENTRIES+1];

    // decode, sequencing and result word
    iol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .op       (op),
        .launch   (tok[0]),
        .ret      (tok[iol_pkg::MAX_ENTRIES])
    );

    // nothing beyond the last cell
    assign cards[iol_pkg::MAX_ENTRIES] = '0;

    // row of cells, token flows from the front toward the back
    for (genvar gi = 0; gi < iol_pkg::MAX_ENTRIES; gi++) begin : g_cell
        iol_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .tok_in     (tok[gi]),
            .right_card (cards[gi+1]),
            .card       (cards[gi]),
            .tok_out    (tok[gi+1])
        );
    end

endmodule

/* design/iol_checker.sv */
// port-level checks for indexed_ordered_list, bound to the top level
// depends on indexed_ordered_list_defines.svh
`include "indexed_ordered_list_defines.svh"

module iol_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result word holds
    `IOL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a word just taken keeps the input closed while it is worked on
    `IOL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a found card always comes with ok status
    `IOL_ASSERT_IMP(a_found_ok, m_tvalid && m_tdata[6], m_tdata[8:7] == 2'd0)

    // rejected words return a zero card and no find
    `IOL_ASSERT_IMP(a_reject_zero, m_tvalid && (m_tdata[8:7] != 2'd0), m_tdata[6:0] == 7'd0)

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (.*);

/* dv/tb_top.sv */
// self-checking testbench for the indexed ordered list of cards
// depends on iol_pkg and indexed_ordered_list; keeps its own copy of the list to predict replies
module tb_top;
    import iol_pkg::*;

    // reply word as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic [CNT_W-1:0]  entry_count;
        logic [STAT_W-1:0] status;
        logic              found;
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
    } list_reply_t;

    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } op_mix_t;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_W'(11);
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = MODE_W'(15);
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_LIMIT = 5000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // predicted list contents and length
    logic [CARD_W-1:0] deck [MAX_ENTRIES];
    int                deck_len;
    list_reply_t       replies_due[$];

    int mismatch_count;
    int reply_count;
    int burst_left;
    int gap_pct;
    int stall_pct;
    int holds_asked;
    int holds_done;
    int hold_left;
    int run_left;
    logic run_ready;

    indexed_ordered_list uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // pull one card out of the predicted list and close the gap
    function automatic logic [CARD_W-1:0] take_card(int pos);
        logic [CARD_W-1:0] c;
        c = deck[pos];
        for (int i = pos; i + 1 < deck_len; i++)
            deck[i] = deck[i + 1];
        deck_len--;
        return c;
    endfunction

    // apply one operation to the predicted list and return the reply it gives
    function automatic list_reply_t apply_list_op(logic [MODE_W-1:0] mode,
                                                  logic [SUIT_W-1:0] suit,
                                                  logic [RANK_W-1:0] rank,
                                                  logic [IDX_W-1:0] idx);
        list_reply_t       r;
        logic [CARD_W-1:0] card;
        logic [CARD_W-1:0] got;
        int                pos;
        int                hit_at;
        r      = '0;
        got    = '0;
        card   = {suit, rank};
        hit_at = -1;
        case (mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_INDEX: begin
                if (deck_len >= MAX_ENTRIES) begin
                    r.status = STAT_FULL;
                end else begin
                    pos = (mode == MODE_INS_FRONT) ? 0 :
                          (mode == MODE_INS_BACK) ? deck_len : int'(idx);
                    if (pos > deck_len) begin
                        r.status = STAT_RANGE;
                    end else begin
                        for (int i = deck_len; i > pos; i--)
                            deck[i] = deck[i - 1];
                        deck[pos] = card;
                        deck_len++;
                    end
                end
            end
            MODE_REPLACE, MODE_READ, MODE_RM_INDEX: begin
                if (deck_len == 0)
                    r.status = STAT_EMPTY;
                else if (int'(idx) >= deck_len)
                    r.status = STAT_RANGE;
                else if (mode == MODE_REPLACE)
                    deck[idx] = card;
                else if (mode == MODE_READ)
                    got = deck[idx];
                else
                    got = take_card(int'(idx));
            end
            MODE_SEARCH, MODE_RM_MATCH: begin
                if (deck_len == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (int i = deck_len - 1; i >= 0; i--)
                        if (deck[i] == card)
                            hit_at = i;
                    r.found = (hit_at >= 0);
                    if (hit_at >= 0 && mode == MODE_RM_MATCH)
                        got = take_card(hit_at);
                end
            end
            MODE_RM_FRONT, MODE_RM_BACK: begin
                if (deck_len == 0)
                    r.status = STAT_EMPTY;
                else
                    got = take_card((mode == MODE_RM_FRONT) ? 0 : deck_len - 1);
            end
            MODE_CLEAR: begin
                deck_len = 0;
            end
            default: begin
            end
        endcase
        r.suit        = got[CARD_W-1:RANK_W];
        r.rank        = got[RANK_W-1:0];
        r.entry_count = CNT_W'(deck_len);
        return r;
    endfunction

    task automatic report_mismatch(string field, int want, int seen);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on reply %0d, %s: expected %0d, got %0d",
                     reply_count, field, want, seen);
    endtask

    // offer one operation word, honoring the burst and gap pattern
    task automatic send_op(logic [MODE_W-1:0] mode, logic [SUIT_W-1:0] suit,
                           logic [RANK_W-1:0] rank, logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            if ($urandom_range(99) < gap_pct) begin
                gap = ($urandom_range(3) == 0) ? $urandom_range(90, 1) : $urandom_range(8, 1);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {{(S_DATA_W - IDX_W - CARD_W - MODE_W){1'b0}}, idx, rank, suit, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        replies_due.push_back(apply_list_op(mode, suit, rank, idx));
    endtask

    // stop offering and wait until every reply is back
    task automatic wait_replies_drained();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // reply checker
    always @(posedge aclk) begin : reply_check
        list_reply_t seen;
        list_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = list_reply_t'(m_tdata);
            reply_count++;
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected reply", 0, 1);
            end else begin
                want = replies_due.pop_front();
                if (seen.suit != want.suit)
                    report_mismatch("out_suit", want.suit, seen.suit);
                if (seen.rank != want.rank)
                    report_mismatch("out_rank", want.rank, seen.rank);
                if (seen.found != want.found)
                    report_mismatch("found", want.found, seen.found);
                if (seen.status != want.status)
                    report_mismatch("status", want.status, seen.status);
                if (seen.entry_count != want.entry_count)
                    report_mismatch("entry_count", want.entry_count, seen.entry_count);
            end
        end
    end

    // receiver: random ready runs, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_left  = ($urandom_range(3) == 0) ? $urandom_range(100, 1) :
                                                       $urandom_range(6, 1);
                run_ready = !($urandom_range(99) < stall_pct);
            end
            run_left--;
            m_tready <= run_ready;
        end
    end

    // every operation that an empty list refuses, plus spare modes and a clear
    task automatic test_empty_list();
        send_op(MODE_READ,      2'd0, 4'd0,  7'd0);
        send_op(MODE_REPLACE,   2'd1, 4'd3,  7'd0);
        send_op(MODE_SEARCH,    2'd2, 4'd7,  7'd0);
        send_op(MODE_RM_MATCH,  2'd3, 4'd12, 7'd0);
        send_op(MODE_RM_FRONT,  2'd0, 4'd0,  7'd0);
        send_op(MODE_RM_BACK,   2'd0, 4'd0,  7'd0);
        send_op(MODE_RM_INDEX,  2'd0, 4'd0,  7'd0);
        send_op(MODE_INS_INDEX, 2'd1, 4'd1,  7'd1);
        send_op(MODE_SPARE_LO,  2'd3, 4'd15, 7'd127);
        send_op(MODE_SPARE_HI,  2'd3, 4'd15, 7'd127);
        send_op(MODE_CLEAR,     2'd0, 4'd0,  7'd0);
    endtask

    // inserts, index bounds, replace, search, front removal by match and by index, back removal
    task automatic test_list_edges();
        send_op(MODE_INS_FRONT, 2'd3, 4'd15, 7'd0);
        send_op(MODE_INS_BACK,  2'd0, 4'd0,  7'd0);
        send_op(MODE_INS_INDEX, 2'd2, 4'd12, 7'd2);
        send_op(MODE_INS_INDEX, 2'd1, 4'd5,  7'd1);
        send_op(MODE_INS_INDEX, 2'd1, 4'd5,  7'd127);
        send_op(MODE_READ,      2'd0, 4'd0,  7'd3);
        send_op(MODE_READ,      2'd0, 4'd0,  7'd4);
        send_op(MODE_READ,      2'd0, 4'd0,  7'd127);
        send_op(MODE_REPLACE,   2'd3, 4'd13, 7'd0);
        send_op(MODE_SEARCH,    2'd2, 4'd12, 7'd0);
        send_op(MODE_SEARCH,    2'd2, 4'd11, 7'd0);
        send_op(MODE_RM_MATCH,  2'd3, 4'd13, 7'd0);
        send_op(MODE_RM_MATCH,  2'd0, 4'd9,  7'd0);
        send_op(MODE_RM_INDEX,  2'd0, 4'd0,  7'd0);
        send_op(MODE_RM_BACK,   2'd0, 4'd0,  7'd0);
        send_op(MODE_RM_INDEX,  2'd0, 4'd0,  7'd5);
        send_op(MODE_CLEAR,     2'd0, 4'd0,  7'd0);
    endtask

    // one random operation, mostly well formed for the current list length
    task automatic send_random_op(op_mix_t mix);
        logic [MODE_W-1:0] mode;
        logic [SUIT_W-1:0] suit;
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  idx;
        logic [CARD_W-1:0] pick;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 3)
            mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        else if (roll < 4)
            mode = MODE_CLEAR;
        else if (mix == MIX_GROW)
            mode = ($urandom_range(99) < 80) ? MODE_W'($urandom_range(MODE_INS_INDEX))
                                             : MODE_W'($urandom_range(MODE_RM_INDEX,
                                                                      MODE_REPLACE));
        else if (mix == MIX_SHRINK)
            mode = ($urandom_range(99) < 65) ? MODE_W'($urandom_range(MODE_RM_INDEX,
                                                                      MODE_RM_MATCH))
                                             : MODE_W'($urandom_range(MODE_RM_INDEX));
        else
            mode = MODE_W'($urandom_range(MODE_RM_INDEX));
        suit = SUIT_W'($urandom_range(3));
        rank = ($urandom_range(9) == 0) ? RANK_W'($urandom_range(15))
                                        : RANK_W'($urandom_range(12));
        // search and remove-match mostly look for a card that is present
        if ((mode == MODE_SEARCH || mode == MODE_RM_MATCH) && deck_len > 0
                && $urandom_range(99) < 60) begin
            pick = deck[$urandom_range(deck_len - 1)];
            suit = pick[CARD_W-1:RANK_W];
            rank = pick[RANK_W-1:0];
        end
        if ($urandom_range(99) < 15)
            idx = IDX_W'($urandom_range(127));
        else if (mode <= MODE_INS_INDEX)
            idx = IDX_W'($urandom_range(deck_len));
        else
            idx = IDX_W'($urandom_range((deck_len > 0) ? deck_len - 1 : 0));
        send_op(mode, suit, rank, idx);
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_output_backpressure();
        gap_pct = 0;
        holds_asked++;
        repeat (12) send_random_op(MIX_ANY);
        wait_replies_drained();
    endtask

    // random traffic in phases of growth, shrinkage and mixed operations
    task automatic test_random_traffic(int total);
        op_mix_t mix;
        int      sent;
        int      phase_len;
        sent = 0;
        mix  = MIX_GROW;
        while (sent < total) begin
            phase_len = $urandom_range(160, 80);
            gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
            for (int i = 0; i < phase_len && sent < total; i++) begin
                send_random_op(mix);
                sent++;
            end
            // every so often let the pipe empty before moving on
            if ($urandom_range(2) == 0)
                wait_replies_drained();
            case ($urandom_range(2))
                0: mix = MIX_GROW;
                1: mix = MIX_SHRINK;
                default: mix = MIX_ANY;
            endcase
        end
    endtask

    // timeout
    initial begin
        #6_400_000;
        $display("indexed_ordered_list test failed");
        $finish;
    end

    // main sequence
    initial begin : main_seq
        int waited;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        deck_len       = 0;
        mismatch_count = 0;
        reply_count    = 0;
        burst_left     = 0;
        gap_pct        = 30;
        stall_pct      = 30;
        holds_asked    = 0;
        holds_done     = 0;
        hold_left      = 0;
        run_left       = 0;
        run_ready      = 1'b1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            deck[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_list_edges();
        wait_replies_drained();
        test_random_traffic(440);
        test_output_backpressure();
        test_random_traffic(440);

        // let the last replies come back, then settle
        s_tvalid <= 1'b0;
        waited = 0;
        while (replies_due.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);
        if (replies_due.size() != 0)
            report_mismatch("replies missing", 0, replies_due.size());
        if (mismatch_count == 0)
            $display("indexed_ordered_list test passed");
        else
            $display("indexed_ordered_list test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/iol_pkg.sv
design/iol_cell.sv
design/iol_ctrl.sv
design/indexed_ordered_list.sv
design/iol_checker.sv
dv/tb_top.sv
